// ===== src/tws_pkg.sv =====
// tick window statistics: shared constants, state enum and control structs
// used by the channel interfaces, datapath, controller and top level
`default_nettype none
package tws_pkg;

   localparam int TIME_WIDTH_DEF  = 48;
   localparam int RATE_FRAC_DEF   = 8;
   localparam int TIME_IN_W       = 48;
   localparam int COUNT_W         = 32;
   localparam int DUR_W           = 32;
   localparam int SUM_W           = 64;
   localparam int RATE_W          = 40;
   localparam int US_W            = 20;
   localparam int PROD_W          = COUNT_W + US_W;

   localparam logic [US_W-1:0]    US_PER_SECOND = 20'd1000000;
   localparam logic [DUR_W-1:0]   WINDOW_RESET  = 32'd1000000;
   localparam logic [RATE_W-1:0]  RATE_MAX      = {RATE_W{1'b1}};

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_END   = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_ACCUM,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic capture_item;
      logic calc;
      logic accum;
      logic mul;
      logic div_start;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic is_end;
      logic close;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== src/tws_channels.sv =====
// valid/ready channel interfaces for event items, result items and the
// window register write port; widths come from tws_pkg
`default_nettype none
interface tws_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [tws_pkg::TIME_IN_W-1:0] time_us;

   modport source (output valid, action, time_us, input ready);
   modport sink   (input valid, action, time_us, output ready);
endinterface

interface tws_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tws_pkg::RATE_W-1:0] rate_hz_q8;
   logic [tws_pkg::DUR_W-1:0]  avg_us;
   logic [tws_pkg::DUR_W-1:0]  max_us;

   modport source (output valid, rate_hz_q8, avg_us, max_us, input ready);
   modport sink   (input valid, rate_hz_q8, avg_us, max_us, output ready);
endinterface

interface tws_csr_if;
   logic                     valid;
   logic                     ready;
   logic [tws_pkg::DUR_W-1:0] window_us;

   modport source (output valid, window_us, input ready);
   modport sink   (input valid, window_us, output ready);
endinterface
`default_nettype wire

// ===== src/tws_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
// standalone, no package dependency
`default_nettype none
module tws_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial, diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // quotient bits shift in where the numerator bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = num_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

endmodule
`default_nettype wire

// ===== src/tws_datapath.sv =====
// tick window statistics datapath: timestamps, accumulators, rate multiply,
// two dividers and the result register; uses tws_pkg and tws_divider
`default_nettype none
module tws_datapath #(
   parameter int TIME_WIDTH         = tws_pkg::TIME_WIDTH_DEF,
   parameter int RATE_FRACTION_BITS = tws_pkg::RATE_FRAC_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tws_pkg::dp_cmd_type             cmd,
   output tws_pkg::dp_status_type               status,
   input  wire logic                            req_action,
   input  wire logic [tws_pkg::TIME_IN_W-1:0]   req_time_us,
   input  wire logic                            csr_valid,
   input  wire logic [tws_pkg::DUR_W-1:0]       csr_window_us,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [tws_pkg::RATE_W-1:0]           rsp_rate_hz_q8,
   output logic [tws_pkg::DUR_W-1:0]            rsp_avg_us,
   output logic [tws_pkg::DUR_W-1:0]            rsp_max_us
);
   import tws_pkg::*;

   localparam int RATE_NUM_W = PROD_W + RATE_FRACTION_BITS;

   logic                  action_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [TIME_WIDTH-1:0] tick_start_ff;
   logic [TIME_WIDTH-1:0] window_start_ff;
   logic                  window_open_ff;
   logic [DUR_W-1:0]      window_ff;
   logic [DUR_W-1:0]      duration_ff;
   logic [TIME_WIDTH-1:0] elapsed_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [DUR_W-1:0]      max_ff;
   logic [PROD_W-1:0]     product_ff;
   logic                  rsp_valid_ff;
   logic [RATE_W-1:0]     rate_ff;
   logic [DUR_W-1:0]      avg_ff;
   logic [DUR_W-1:0]      max_out_ff;

   logic [TIME_WIDTH-1:0] tick_diff;
   logic [RATE_NUM_W-1:0] rate_num;
   logic [RATE_NUM_W-1:0] rate_quot;
   logic [SUM_W-1:0]      avg_quot;
   logic                  rate_busy, rate_done, avg_busy, avg_done;
   logic [RATE_W-1:0]     rate_sat;

   assign tick_diff = now_ff - tick_start_ff;
   assign rate_num  = RATE_NUM_W'(product_ff) << RATE_FRACTION_BITS;

   tws_divider #(.NUM_W(RATE_NUM_W), .DEN_W(TIME_WIDTH)) u_rate_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (rate_num),
      .den   (elapsed_ff),
      .busy  (rate_busy),
      .done  (rate_done),
      .quot  (rate_quot)
   );

   tws_divider #(.NUM_W(SUM_W), .DEN_W(COUNT_W)) u_avg_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (sum_ff),
      .den   (count_ff),
      .busy  (avg_busy),
      .done  (avg_done),
      .quot  (avg_quot)
   );

   // zero elapsed time gives an all-ones quotient, which saturates here too
   assign rate_sat = (|rate_quot[RATE_NUM_W-1:RATE_W]) ? RATE_MAX : rate_quot[RATE_W-1:0];

   always_comb begin
      status.is_end   = action_ff == ACTION_END;
      status.close    = elapsed_ff >= TIME_WIDTH'(window_ff);
      status.div_done = rate_done && avg_done && !rate_busy && !avg_busy;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_item) begin
         action_ff <= req_action;
         now_ff    <= TIME_WIDTH'(req_time_us);
      end
      if (cmd.calc) begin
         duration_ff <= tick_diff[DUR_W-1:0];
         elapsed_ff  <= now_ff - window_start_ff;
      end
      if (cmd.mul) begin
         product_ff <= count_ff * US_PER_SECOND;
      end
      if (cmd.load_out) begin
         rate_ff    <= rate_sat;
         avg_ff     <= (count_ff == '0) ? '0 : avg_quot[DUR_W-1:0];
         max_out_ff <= max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff       <= WINDOW_RESET;
         tick_start_ff   <= '0;
         window_start_ff <= '0;
         window_open_ff  <= 1'b0;
         count_ff        <= '0;
         sum_ff          <= '0;
         max_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            window_ff <= csr_window_us;
         end
         if (cmd.calc && !status.is_end) begin
            tick_start_ff <= now_ff;
            if (!window_open_ff) begin
               window_start_ff <= now_ff;
               window_open_ff  <= 1'b1;
            end
         end
         if (cmd.accum) begin
            sum_ff   <= sum_ff + SUM_W'(duration_ff);
            count_ff <= count_ff + COUNT_W'(1);
            if (duration_ff > max_ff) begin
               max_ff <= duration_ff;
            end
         end
         // closing the window restarts it at the closing item's time
         if (cmd.load_out) begin
            count_ff        <= '0;
            sum_ff          <= '0;
            max_ff          <= '0;
            window_start_ff <= now_ff;
            window_open_ff  <= 1'b1;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rate_hz_q8 = rate_ff;
   assign rsp_avg_us     = avg_ff;
   assign rsp_max_us     = max_out_ff;

   a_clear_on_close: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (count_ff == '0) && (sum_ff == '0) && (max_ff == '0) && rsp_valid_ff)
      else $error("accumulators not cleared at window close");

endmodule
`default_nettype wire

// ===== src/tws_ctrl.sv =====
// tick window statistics controller: sequences capture, update, multiply,
// division and result load; uses tws_pkg state and command types
`default_nettype none
module tws_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tws_pkg::dp_status_type status,
   output tws_pkg::dp_cmd_type         cmd
);
   import tws_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = status.is_end ? ST_ACCUM : ST_IDLE;
         end
         ST_ACCUM: begin
            state_in = status.close ? ST_MUL : ST_IDLE;
         end
         ST_MUL:       state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = state_ff == ST_IDLE;
      cmd.capture_item = (state_ff == ST_IDLE) && req_valid;
      cmd.calc         = state_ff == ST_CALC;
      cmd.accum        = state_ff == ST_ACCUM;
      cmd.mul          = state_ff == ST_MUL;
      cmd.div_start    = state_ff == ST_DIV_START;
      cmd.load_out     = (state_ff == ST_OUT) && status.out_free;
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a pending item");
   a_div_after_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) && status.close |=> state_ff == ST_MUL)
      else $error("window close not followed by rate multiply");

endmodule
`default_nettype wire

// ===== src/tick_window_statistics.sv =====
// Tick-duration window monitor.
// req channel: one item per event, action 0 = tick start, 1 = tick end, with
// a free-running microsecond timestamp (low TIME_WIDTH bits used).
// rsp channel: one item when an end event finds the window elapsed: rate in
// Q.RATE_FRACTION_BITS Hz (saturating), mean and longest tick duration.
// csr channel: writes the window length in microseconds, always ready; write
// only while no item is in flight.
// Sequence: a start event is accepted and then updates the timestamps; an end
// event that keeps the window open also accumulates. A closing end event goes
// on through multiply, divider start, division wait and result load: the rate
// quotient has 52 + RATE_FRACTION_BITS bits and the average 64, from one-bit
// restoring division run side by side; the wait ends when both are done.
// Reset clears the tick and window start timestamps and the accumulators and
// sets the window to 1000000 us. A finished result waits in the output
// register while the next item is accepted; a later closing item holds in its
// last step until the receiver takes the earlier result.
`default_nettype none
module tick_window_statistics #(
   parameter int TIME_WIDTH         = tws_pkg::TIME_WIDTH_DEF,
   parameter int RATE_FRACTION_BITS = tws_pkg::RATE_FRAC_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tws_req_if.sink   req,
   tws_rsp_if.source rsp,
   tws_csr_if.sink   csr
);
   import tws_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr.ready = 1'b1;

   tws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tws_datapath #(
      .TIME_WIDTH         (TIME_WIDTH),
      .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req.action),
      .req_time_us    (req.time_us),
      .csr_valid      (csr.valid),
      .csr_window_us  (csr.window_us),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_rate_hz_q8 (rsp.rate_hz_q8),
      .rsp_avg_us     (rsp.avg_us),
      .rsp_max_us     (rsp.max_us)
   );

endmodule
`default_nettype wire
